>>> src/nfc_host_frame_receiver_core_defines.svh
// Assertion macros of the frame receiver, used by its top level.
// No dependencies; included by files that carry assertions.
`ifndef NFC_HOST_FRAME_RECEIVER_CORE_DEFINES_SVH
`define NFC_HOST_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication
`define NFCHR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver assertion failed");

// next-cycle implication
`define NFCHR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver assertion failed");

`endif

>>> src/nfchr_pkg.sv
// Types, codes and constants of the host-link frame receiver.
// No dependencies; used by every module of the block.
package nfchr_pkg;

   localparam int unsigned SKIP_LIMIT = 255;
   localparam int unsigned SKIP_W     = 9;

   localparam logic [7:0] START_LO = 8'h00;
   localparam logic [7:0] START_HI = 8'hFF;
   localparam logic [7:0] ACK_LCS  = 8'hFF;

   // parser phases
   localparam logic [2:0] PH_HUNT_FIRST = 3'd0;
   localparam logic [2:0] PH_HUNT       = 3'd1;
   localparam logic [2:0] PH_LEN        = 3'd2;
   localparam logic [2:0] PH_LCS        = 3'd3;
   localparam logic [2:0] PH_TFI        = 3'd4;
   localparam logic [2:0] PH_CMD        = 3'd5;
   localparam logic [2:0] PH_DATA       = 3'd6;
   localparam logic [2:0] PH_DCS        = 3'd7;

   // end-of-frame status codes
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_ACK_OK      = 4'd1;
   localparam logic [3:0] ST_NO_START    = 4'd2;
   localparam logic [3:0] ST_LEN_CKSUM   = 4'd3;
   localparam logic [3:0] ST_BAD_ID      = 4'd4;
   localparam logic [3:0] ST_BAD_CODE    = 4'd5;
   localparam logic [3:0] ST_SHORT_LEN   = 4'd6;
   localparam logic [3:0] ST_DATA_CKSUM  = 4'd7;
   localparam logic [3:0] ST_ACK_LEN     = 4'd8;
   localparam logic [3:0] ST_ACK_CKSUM   = 4'd9;

   // register indexes
   localparam logic [1:0] REG_EXPECT_ACK  = 2'd0;
   localparam logic [1:0] REG_EXPECTED_CMD = 2'd1;
   localparam logic [1:0] REG_FRAME_ID    = 2'd2;

   localparam logic [7:0] FRAME_ID_RESET = 8'd213;

   typedef struct packed {
      logic       expect_ack;
      logic [7:0] expected_command;
      logic [7:0] expected_tfi;
   } cfg_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] data_byte;
      logic       end_of_frame;
      logic [3:0] status;
   } step_type;

endpackage

>>> src/nfchr_csr.sv
// Configuration registers of the frame receiver behind an APB-style port.
// Depends on nfchr_pkg.
module nfchr_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output nfchr_pkg::cfg_type cfg
);

   nfchr_pkg::cfg_type cfg_ff, cfg_in;
   logic               wr_en;
   logic [1:0]         reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            nfchr_pkg::REG_EXPECT_ACK:   cfg_in.expect_ack       = csr_pwdata[0];
            nfchr_pkg::REG_EXPECTED_CMD: cfg_in.expected_command = csr_pwdata[7:0];
            nfchr_pkg::REG_FRAME_ID:     cfg_in.expected_tfi     = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expect_ack       <= 1'b0;
         cfg_ff.expected_command <= 8'd0;
         cfg_ff.expected_tfi     <= nfchr_pkg::FRAME_ID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         nfchr_pkg::REG_EXPECT_ACK:   csr_prdata = {31'd0, cfg_ff.expect_ack};
         nfchr_pkg::REG_EXPECTED_CMD: csr_prdata = {24'd0, cfg_ff.expected_command};
         nfchr_pkg::REG_FRAME_ID:     csr_prdata = {24'd0, cfg_ff.expected_tfi};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> src/nfchr_parser.sv
// Input beat register and frame parser state machine.
// Depends on nfchr_pkg.
module nfchr_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  nfchr_pkg::cfg_type cfg,
   input  logic               slot_free,
   output logic               stage_full,
   output nfchr_pkg::step_type step
);

   logic                         in_valid_ff, in_valid_in;
   logic [7:0]                   in_byte_ff, in_byte_in;
   logic                         adv;

   logic [2:0]                   phase_ff, phase_in;
   logic [7:0]                   prev_ff, prev_in;
   logic [nfchr_pkg::SKIP_W-1:0] skip_ff, skip_in;
   logic [7:0]                   len_ff, len_in;
   logic [7:0]                   left_ff, left_in;
   logic [7:0]                   sum_ff, sum_in;

   logic [7:0]                   b;
   logic [7:0]                   left_dec;
   logic                         fin;
   logic [3:0]                   fin_code;
   logic                         emit_data;

   assign adv        = in_valid_ff & slot_free;
   assign req_tready = ~in_valid_ff | adv;
   assign stage_full = in_valid_ff;
   assign b          = in_byte_ff;
   assign left_dec   = left_ff - 8'd1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (adv) in_valid_in = 1'b0;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      prev_in   = prev_ff;
      skip_in   = skip_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      fin       = 1'b0;
      fin_code  = nfchr_pkg::ST_OK;
      emit_data = 1'b0;
      unique case (phase_ff)
         nfchr_pkg::PH_HUNT_FIRST: begin
            prev_in  = b;
            phase_in = nfchr_pkg::PH_HUNT;
         end
         nfchr_pkg::PH_HUNT: begin
            if (prev_ff == nfchr_pkg::START_LO && b == nfchr_pkg::START_HI) begin
               skip_in  = '0;
               prev_in  = b;
               phase_in = nfchr_pkg::PH_LEN;
            end else if (skip_ff >= nfchr_pkg::SKIP_W'(nfchr_pkg::SKIP_LIMIT)) begin
               fin      = 1'b1;
               fin_code = nfchr_pkg::ST_NO_START;
            end else begin
               skip_in = skip_ff + 1'b1;
               prev_in = b;
            end
         end
         nfchr_pkg::PH_LEN: begin
            if (cfg.expect_ack && b != 8'd0) begin
               fin      = 1'b1;
               fin_code = nfchr_pkg::ST_ACK_LEN;
            end else begin
               len_in   = b;
               phase_in = nfchr_pkg::PH_LCS;
            end
         end
         nfchr_pkg::PH_LCS: begin
            if (cfg.expect_ack) begin
               fin      = 1'b1;
               fin_code = (b != nfchr_pkg::ACK_LCS) ? nfchr_pkg::ST_ACK_CKSUM
                                                     : nfchr_pkg::ST_ACK_OK;
            end else if (8'(len_ff + b) != 8'd0) begin
               fin      = 1'b1;
               fin_code = nfchr_pkg::ST_LEN_CKSUM;
            end else if (len_ff < 8'd2) begin
               fin      = 1'b1;
               fin_code = nfchr_pkg::ST_SHORT_LEN;
            end else begin
               phase_in = nfchr_pkg::PH_TFI;
            end
         end
         nfchr_pkg::PH_TFI: begin
            if (b != cfg.expected_tfi) begin
               fin      = 1'b1;
               fin_code = nfchr_pkg::ST_BAD_ID;
            end else begin
               sum_in   = b;
               phase_in = nfchr_pkg::PH_CMD;
            end
         end
         nfchr_pkg::PH_CMD: begin
            if (b != 8'(cfg.expected_command + 8'd1)) begin
               fin      = 1'b1;
               fin_code = nfchr_pkg::ST_BAD_CODE;
            end else begin
               sum_in   = sum_ff + b;
               left_in  = len_ff - 8'd2;
               phase_in = (len_ff == 8'd2) ? nfchr_pkg::PH_DCS : nfchr_pkg::PH_DATA;
            end
         end
         nfchr_pkg::PH_DATA: begin
            sum_in    = sum_ff + b;
            left_in   = left_dec;
            emit_data = 1'b1;
            if (left_dec == 8'd0) phase_in = nfchr_pkg::PH_DCS;
         end
         nfchr_pkg::PH_DCS: begin
            fin      = 1'b1;
            fin_code = (8'(sum_ff + b) != 8'd0) ? nfchr_pkg::ST_DATA_CKSUM
                                                : nfchr_pkg::ST_OK;
         end
      endcase
      if (fin) begin
         phase_in = nfchr_pkg::PH_HUNT_FIRST;
         prev_in  = 8'hFF;
         skip_in  = '0;
      end
   end

   always_comb begin
      step.emit         = adv & (fin | emit_data);
      step.data_byte    = fin ? 8'd0 : b;
      step.end_of_frame = fin;
      step.status       = fin ? fin_code : nfchr_pkg::ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= nfchr_pkg::PH_HUNT_FIRST;
         prev_ff     <= 8'hFF;
         skip_ff     <= '0;
         len_ff      <= 8'd0;
         left_ff     <= 8'd0;
         sum_ff      <= 8'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (adv) begin
            phase_ff <= phase_in;
            prev_ff  <= prev_in;
            skip_ff  <= skip_in;
            len_ff   <= len_in;
            left_ff  <= left_in;
            sum_ff   <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

endmodule

>>> src/nfchr_outreg.sv
// Result register driving the response stream.
// Depends on nfchr_pkg.
module nfchr_outreg (
   input  logic                clock,
   input  logic                reset,
   input  nfchr_pkg::step_type step,
   output logic                slot_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic [3:0]          rsp_tuser
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic [3:0] user_ff;

   assign slot_free = ~valid_ff | rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) valid_in = 1'b0;
      if (step.emit)  valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.emit) begin
         data_ff <= step.data_byte;
         last_ff <= step.end_of_frame;
         user_ff <= step.status;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

>>> src/nfc_host_frame_receiver_core.sv
// Top level of the host-link frame receiver: parser, result register, registers.
// Depends on nfchr_pkg, nfchr_csr, nfchr_parser, nfchr_outreg and the defines header.
//
// Usage:
//   req_* carries one received serial byte per beat. rsp_* carries results:
//   a payload beat (tlast low, tuser 0) for each data byte of a frame with a good header,
//   and one end-of-frame beat (tlast high, tdata 0) whose tuser holds the
//   frame status. Bytes that produce no result give no rsp beat.
//   csr_* sets expect_ack (0x0), expected_command (0x4), the expected TFI (0x8);
//   write them only while the block is idle.
// Path: a byte taken is held in the input register, where it is parsed, and
//   its result beat is registered in the result register.
// Throughput: one byte per cycle unless the output stalls; the parse is a
//   single pass of compares and 8-bit adds between the input and result registers.
// Reset: clears the registers to their defaults, empties both stages and
//   starts hunting for the start code.
// Stall: while rsp_tready is low and a result waits, the parser holds; one
//   more byte is still taken into the input register, then req_tready drops.
`include "nfc_host_frame_receiver_core_defines.svh"

module nfc_host_frame_receiver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] data_byte
   output logic        rsp_tlast,
   output logic [3:0]  rsp_tuser,    // [3:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   nfchr_pkg::cfg_type  cfg;
   nfchr_pkg::step_type step;
   logic                slot_free;
   logic                stage_full;

   nfchr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   nfchr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .slot_free  (slot_free),
      .stage_full (stage_full),
      .step       (step)
   );

   nfchr_outreg u_outreg (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   `NFCHR_ASSERT_IMP(a_eof_zero_data, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata == 8'd0)
   `NFCHR_ASSERT_IMP(a_payload_ok, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tuser == nfchr_pkg::ST_OK)
   `NFCHR_ASSERT_IMP(a_status_range, clock, reset, rsp_tvalid, rsp_tuser <= nfchr_pkg::ST_ACK_CKSUM)
   `NFCHR_ASSERT_IMP(a_full_stall, clock, reset, stage_full && rsp_tvalid && !rsp_tready, !req_tready)
   `NFCHR_ASSERT_NXT(a_emit_shows, clock, reset, step.emit, rsp_tvalid)

endmodule
